@@ design/bale_pkg.sv @@
// ----------------------------------------------------------------------------
// bale_pkg: shared definitions for the buddy allocator with LRU eviction
// Sizes, codes, the result record and the output-stage control group.
// ----------------------------------------------------------------------------
package bale_pkg;

  localparam int NUM_PAGES   = 16;
  localparam int MAX_RECORDS = 32;
  localparam int NUM_PIDS    = 16;

  // pool is the largest power of two of pages that fits
  localparam int POOL_ORDER = $clog2(NUM_PAGES + 1) - 1;
  localparam int POOL_PAGES = 1 << POOL_ORDER;

  localparam int PG_W   = $clog2(NUM_PAGES);
  localparam int PGC_W  = PG_W + 1;
  localparam int ORD_W  = 3;
  localparam int REC_W  = $clog2(MAX_RECORDS);
  localparam int RECC_W = REC_W + 1;
  localparam int LRC_W  = $clog2(NUM_PAGES + 1);

  // fixed field widths
  localparam int PID_W   = 4;
  localparam int AID_W   = 8;
  localparam int REQ_W   = 5;
  localparam int START_W = 4;
  localparam int KIND_W  = 3;

  // opcodes
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_ACCESS  = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_TERM    = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_PLACED   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_HIT      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EVICTED  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [PID_W-1:0]   pid;
    logic [AID_W-1:0]   aid;
    logic [START_W-1:0] start;
    logic [ORD_W-1:0]   order;
  } res_t;

  typedef struct packed {
    logic emit;
    logic finish;
  } ostage_ctl_t;

  typedef struct packed {
    logic         valid;
    logic         res;
    logic [PID_W-1:0] pid;
    logic [AID_W-1:0] aid;
    logic [REQ_W-1:0] size;
    logic [PG_W-1:0]  start;
  } rec_t;

  // smallest order whose block holds n pages
  function automatic logic [ORD_W-1:0] order_for(logic [REQ_W-1:0] n);
    logic [ORD_W-1:0] k;
    k = ORD_W'(POOL_ORDER);
    for (int i = POOL_ORDER; i >= 0; i--) begin
      if ((32'd1 << i) >= 32'(n)) k = ORD_W'(i);
    end
    return k;
  endfunction

endpackage

@@ design/bale_out_stage.sv @@
// ----------------------------------------------------------------------------
// bale_out_stage: result holding stage and output register
// Holds the newest result until it is known whether it ends the request.
// ----------------------------------------------------------------------------
module bale_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bale_pkg::ostage_ctl_t ctl,
  input  bale_pkg::res_t       res,
  output logic                 ok,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // owner_pid[3:0], owner_aid[11:4], block_start[15:12], block_order[18:16],
  // zero fill
  output logic [23:0]          out_tdata,
  // kind[2:0]
  output logic [2:0]           out_tuser,
  output logic                 out_tlast
);

  bale_pkg::res_t pend_r;
  logic           pend_v_r;
  bale_pkg::res_t out_r;
  logic           out_v_r;
  logic           out_v_nxt;
  logic           last_r;

  assign ok = !pend_v_r || !out_v_r || out_tready;

  // output register refills from the pending result or drains
  assign out_v_nxt = (ok && pend_v_r && (ctl.emit || ctl.finish)) ||
                     (out_v_r && !out_tready);

  // pending result moves out with last known
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      if (ctl.emit && ok) begin
        if (pend_v_r) begin
          out_r  <= pend_r;
          last_r <= 1'b0;
        end
        pend_r   <= res;
        pend_v_r <= 1'b1;
      end else if (ctl.finish && ok) begin
        if (pend_v_r) begin
          out_r  <= pend_r;
          last_r <= 1'b1;
        end
        pend_v_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {5'b00000, out_r.order, out_r.start, out_r.aid, out_r.pid};
  assign out_tuser  = out_r.kind;

endmodule

@@ design/buddy_allocator_lru_evict_unit.sv @@
// ----------------------------------------------------------------------------
// buddy_allocator_lru_evict_unit: buddy page allocator with LRU eviction
// Sequencer over block, record and LRU tables with one result stage.
// ----------------------------------------------------------------------------
// One request is handled at a time; in_tready is high only while idle. The
// sequencer walks one table entry per cycle: a record lookup sweeps all 32
// records, a free-block search walks the block heads, an LRU removal sweeps
// the used LRU entries and each merge level walks the heads to find the
// buddy. Each eviction adds a record sweep, an LRU sweep and the merge walk,
// and terminate sweeps all records plus a release per resident block.
// Results leave through a holding stage, so output stalls slow the
// sequencer only when a second result is ready.
// ----------------------------------------------------------------------------
module buddy_allocator_lru_evict_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pid[3:0], aid[11:4], pages_requested[16:12], zero fill
  input  logic [23:0] in_tdata,
  // opcode[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // owner_pid[3:0], owner_aid[11:4], block_start[15:12], block_order[18:16],
  // zero fill
  output logic [23:0] out_tdata,
  // kind[2:0]
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  localparam int PG_W  = bale_pkg::PG_W;
  localparam int PGC_W = bale_pkg::PGC_W;
  localparam int ORD_W = bale_pkg::ORD_W;
  localparam int REC_W = bale_pkg::REC_W;
  localparam int RECC_W = bale_pkg::RECC_W;
  localparam int LRC_W = bale_pkg::LRC_W;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DEC, ST_FIND, ST_A_FOUND, ST_A_WRITE, ST_AC_FOUND, ST_AC_APP,
    ST_RL_FOUND, ST_TERM, ST_REL, ST_REL_FREE, ST_REL_END, ST_P_INIT,
    ST_P_SCAN, ST_P_DEC, ST_P_EVF, ST_P_EVFREE, ST_P_SPLIT, ST_P_FIN,
    ST_LRM, ST_FR_INIT, ST_FR_CHK, ST_FR_WALK, ST_FIN
  } state_t;

  state_t state_r, sub_ret_r, rel_ret_r;

  // tables
  logic [ORD_W-1:0]  order_r [bale_pkg::NUM_PAGES];
  logic              used_r  [bale_pkg::NUM_PAGES];
  logic [11:0]       owner_r [bale_pkg::NUM_PAGES];
  bale_pkg::rec_t    rec_r   [bale_pkg::MAX_RECORDS];
  logic [PG_W-1:0]   lru_r   [bale_pkg::NUM_PAGES];
  logic [LRC_W-1:0]  lru_cnt_r;

  // request
  logic [1:0]  op_r;
  logic [3:0]  pid_r;
  logic [7:0]  aid_r;
  logic [4:0]  req_r;

  // working registers
  logic [REC_W-1:0]  cur_r;
  logic [RECC_W-1:0] ri_r;
  logic [3:0]        tpid_r;
  logic [7:0]        taid_r;
  logic              fnd_v_r, inv_v_r, nr_v_r;
  logic [REC_W-1:0]  fnd_i_r, inv_i_r, nr_i_r;
  logic [PG_W-1:0]   s_r, b_r, best_q_r;
  logic [PGC_W-1:0]  q_r;
  logic [ORD_W-1:0]  o_r, k_r, best_o_r;
  logic              best_v_r;
  logic [11:0]       own_r;
  logic [LRC_W-1:0]  li_r;
  logic              lfound_r;

  // combinational helpers
  bale_pkg::rec_t    rc, rf, rt;
  logic [PG_W-1:0]   qi;
  logic [ORD_W-1:0]  ord_q;
  logic [PGC_W-1:0]  q_step;
  logic [4:0]        rq;
  logic [LRC_W-1:0]  li_nx;
  logic              lf;
  logic [PG_W-1:0]   split_buddy;
  logic [ORD_W-1:0]  o_dn;
  logic [PG_W-1:0]   lru_head;

  logic              ok;
  bale_pkg::ostage_ctl_t ctl;
  bale_pkg::res_t    res;

  assign rc       = rec_r[cur_r];
  assign rf       = rec_r[ri_r[REC_W-1:0]];
  assign rt       = rec_r[ri_r[REC_W-1:0]];
  assign qi       = q_r[PG_W-1:0];
  assign ord_q    = order_r[qi];
  assign q_step   = q_r + (PGC_W'(1) << ord_q);
  assign rq       = (in_tdata[16:12] == 5'd0) ? 5'd1 : in_tdata[16:12];
  assign li_nx    = li_r + LRC_W'(1);
  assign lf       = lfound_r || (lru_r[li_r[PG_W-1:0]] == s_r);
  assign o_dn     = o_r - ORD_W'(1);
  assign split_buddy = qi + (PG_W'(1) << o_dn);
  assign lru_head = lru_r[0];
  assign in_tready = (state_r == ST_IDLE);

  // result selection per state
  always_comb begin
    ctl = '0;
    res = '0;
    unique case (state_r)
      ST_DEC: begin
        if (op_r == bale_pkg::OP_ALLOC && req_r > 5'(bale_pkg::POOL_PAGES)) begin
          ctl.emit = 1'b1;
          res.kind = bale_pkg::KIND_REJECTED;
          res.pid  = pid_r;
          res.aid  = aid_r;
        end
      end
      ST_A_FOUND: begin
        if (!fnd_v_r && !inv_v_r && !nr_v_r) begin
          ctl.emit = 1'b1;
          res.kind = bale_pkg::KIND_REJECTED;
          res.pid  = pid_r;
          res.aid  = aid_r;
        end
      end
      ST_REL: begin
        ctl.emit = 1'b1;
        res.kind = bale_pkg::KIND_RELEASED;
        res.pid  = rc.pid;
        res.aid  = rc.aid;
        if (rc.res) begin
          res.start = 4'(rc.start);
          res.order = order_r[rc.start];
        end
      end
      ST_AC_APP: begin
        ctl.emit  = 1'b1;
        res.kind  = bale_pkg::KIND_HIT;
        res.pid   = pid_r;
        res.aid   = aid_r;
        res.start = 4'(s_r);
        res.order = order_r[s_r];
      end
      ST_P_DEC: begin
        if (!best_v_r && lru_cnt_r == '0) begin
          ctl.emit = 1'b1;
          res.kind = bale_pkg::KIND_REJECTED;
          res.pid  = rc.pid;
          res.aid  = rc.aid;
        end
      end
      ST_P_EVF: begin
        ctl.emit  = 1'b1;
        res.kind  = bale_pkg::KIND_EVICTED;
        res.pid   = own_r[11:8];
        res.aid   = own_r[7:0];
        res.start = 4'(s_r);
        res.order = order_r[s_r];
      end
      ST_P_FIN: begin
        ctl.emit  = 1'b1;
        res.kind  = bale_pkg::KIND_PLACED;
        res.pid   = rc.pid;
        res.aid   = rc.aid;
        res.start = 4'(qi);
        res.order = k_r;
      end
      ST_FIN: ctl.finish = 1'b1;
      default: ;
    endcase
  end

  bale_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .res        (res),
    .ok         (ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // sequencer and tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      sub_ret_r <= ST_IDLE;
      rel_ret_r <= ST_IDLE;
      lru_cnt_r <= '0;
      for (int i = 0; i < bale_pkg::NUM_PAGES; i++) begin
        order_r[i] <= '0;
        used_r[i]  <= 1'b0;
        owner_r[i] <= '0;
      end
      order_r[0] <= ORD_W'(bale_pkg::POOL_ORDER);
      for (int i = 0; i < bale_pkg::MAX_RECORDS; i++) begin
        rec_r[i].valid <= 1'b0;
        rec_r[i].res   <= 1'b0;
      end
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            op_r    <= in_tuser;
            pid_r   <= in_tdata[3:0];
            aid_r   <= in_tdata[11:4];
            req_r   <= rq;
            tpid_r  <= in_tdata[3:0];
            taid_r  <= in_tdata[11:4];
            ri_r    <= '0;
            fnd_v_r <= 1'b0;
            inv_v_r <= 1'b0;
            nr_v_r  <= 1'b0;
            state_r <= ST_DEC;
          end
        end
        ST_DEC: begin
          if (32'(pid_r) >= bale_pkg::NUM_PIDS) begin
            state_r <= ST_FIN;
          end else begin
            unique case (op_r)
              bale_pkg::OP_ALLOC: begin
                if (req_r > 5'(bale_pkg::POOL_PAGES)) begin
                  if (ok) state_r <= ST_FIN;
                end else begin
                  sub_ret_r <= ST_A_FOUND;
                  state_r   <= ST_FIND;
                end
              end
              bale_pkg::OP_ACCESS: begin
                sub_ret_r <= ST_AC_FOUND;
                state_r   <= ST_FIND;
              end
              bale_pkg::OP_RELEASE: begin
                sub_ret_r <= ST_RL_FOUND;
                state_r   <= ST_FIND;
              end
              bale_pkg::OP_TERM: state_r <= ST_TERM;
              default: state_r <= ST_FIN;
            endcase
          end
        end
        // record sweep
        ST_FIND: begin
          if (ri_r == RECC_W'(bale_pkg::MAX_RECORDS)) begin
            state_r <= sub_ret_r;
          end else begin
            if (rf.valid && rf.pid == tpid_r && rf.aid == taid_r && !fnd_v_r) begin
              fnd_v_r <= 1'b1;
              fnd_i_r <= ri_r[REC_W-1:0];
            end
            if (!rf.valid && !inv_v_r) begin
              inv_v_r <= 1'b1;
              inv_i_r <= ri_r[REC_W-1:0];
            end
            if (!rf.res && !nr_v_r) begin
              nr_v_r <= 1'b1;
              nr_i_r <= ri_r[REC_W-1:0];
            end
            ri_r <= ri_r + RECC_W'(1);
          end
        end
        ST_A_FOUND: begin
          if (fnd_v_r) begin
            cur_r     <= fnd_i_r;
            rel_ret_r <= ST_A_WRITE;
            state_r   <= ST_REL;
          end else if (inv_v_r) begin
            cur_r   <= inv_i_r;
            state_r <= ST_A_WRITE;
          end else if (nr_v_r) begin
            cur_r   <= nr_i_r;
            state_r <= ST_A_WRITE;
          end else if (ok) begin
            state_r <= ST_FIN;
          end
        end
        ST_A_WRITE: begin
          rec_r[cur_r] <= '{valid: 1'b1, res: 1'b0, pid: pid_r, aid: aid_r,
                            size: req_r, start: '0};
          state_r <= ST_P_INIT;
        end
        ST_AC_FOUND: begin
          if (!fnd_v_r) begin
            state_r <= ST_FIN;
          end else begin
            cur_r <= fnd_i_r;
            if (rec_r[fnd_i_r].res) begin
              s_r       <= rec_r[fnd_i_r].start;
              li_r      <= '0;
              lfound_r  <= 1'b0;
              sub_ret_r <= ST_AC_APP;
              state_r   <= ST_LRM;
            end else begin
              state_r <= ST_P_INIT;
            end
          end
        end
        ST_AC_APP: begin
          if (ok) begin
            if (lru_cnt_r < LRC_W'(bale_pkg::NUM_PAGES)) begin
              lru_r[lru_cnt_r[PG_W-1:0]] <= s_r;
              lru_cnt_r <= lru_cnt_r + LRC_W'(1);
            end
            state_r <= ST_FIN;
          end
        end
        ST_RL_FOUND: begin
          if (!fnd_v_r) begin
            state_r <= ST_FIN;
          end else begin
            cur_r     <= fnd_i_r;
            rel_ret_r <= ST_FIN;
            state_r   <= ST_REL;
          end
        end
        // terminate: sweep records of the process
        ST_TERM: begin
          if (ri_r == RECC_W'(bale_pkg::MAX_RECORDS)) begin
            state_r <= ST_FIN;
          end else begin
            ri_r <= ri_r + RECC_W'(1);
            if (rt.valid && rt.pid == pid_r) begin
              cur_r <= ri_r[REC_W-1:0];
              if (rt.res) begin
                rel_ret_r <= ST_TERM;
                state_r   <= ST_REL;
              end else begin
                rec_r[ri_r[REC_W-1:0]].valid <= 1'b0;
              end
            end
          end
        end
        // release one record
        ST_REL: begin
          if (ok) begin
            if (rc.res) begin
              s_r       <= rc.start;
              li_r      <= '0;
              lfound_r  <= 1'b0;
              sub_ret_r <= ST_REL_FREE;
              state_r   <= ST_LRM;
            end else begin
              rec_r[cur_r].valid <= 1'b0;
              rec_r[cur_r].res   <= 1'b0;
              state_r <= rel_ret_r;
            end
          end
        end
        ST_REL_FREE: begin
          sub_ret_r <= ST_REL_END;
          state_r   <= ST_FR_INIT;
        end
        ST_REL_END: begin
          rec_r[cur_r].valid <= 1'b0;
          rec_r[cur_r].res   <= 1'b0;
          state_r <= rel_ret_r;
        end
        // placement: search smallest fitting free block
        ST_P_INIT: begin
          k_r      <= bale_pkg::order_for(rc.size);
          q_r      <= '0;
          best_v_r <= 1'b0;
          state_r  <= ST_P_SCAN;
        end
        ST_P_SCAN: begin
          if (q_r >= PGC_W'(bale_pkg::POOL_PAGES)) begin
            state_r <= ST_P_DEC;
          end else begin
            if (!used_r[qi] && ord_q >= k_r && (!best_v_r || ord_q < best_o_r)) begin
              best_v_r <= 1'b1;
              best_q_r <= qi;
              best_o_r <= ord_q;
            end
            q_r <= q_step;
          end
        end
        ST_P_DEC: begin
          if (best_v_r) begin
            q_r     <= PGC_W'(best_q_r);
            o_r     <= best_o_r;
            state_r <= ST_P_SPLIT;
          end else if (lru_cnt_r == '0) begin
            if (ok) state_r <= ST_FIN;
          end else begin
            s_r       <= lru_head;
            own_r     <= owner_r[lru_head];
            tpid_r    <= owner_r[lru_head][11:8];
            taid_r    <= owner_r[lru_head][7:0];
            ri_r      <= '0;
            fnd_v_r   <= 1'b0;
            inv_v_r   <= 1'b0;
            nr_v_r    <= 1'b0;
            sub_ret_r <= ST_P_EVF;
            state_r   <= ST_FIND;
          end
        end
        ST_P_EVF: begin
          if (ok) begin
            if (fnd_v_r) rec_r[fnd_i_r].res <= 1'b0;
            li_r      <= '0;
            lfound_r  <= 1'b0;
            sub_ret_r <= ST_P_EVFREE;
            state_r   <= ST_LRM;
          end
        end
        ST_P_EVFREE: begin
          sub_ret_r <= ST_P_INIT;
          state_r   <= ST_FR_INIT;
        end
        ST_P_SPLIT: begin
          if (o_r > k_r) begin
            order_r[qi]          <= o_dn;
            order_r[split_buddy] <= o_dn;
            used_r[split_buddy]  <= 1'b0;
            owner_r[split_buddy] <= '0;
            o_r <= o_dn;
          end else begin
            state_r <= ST_P_FIN;
          end
        end
        ST_P_FIN: begin
          if (ok) begin
            used_r[qi]  <= 1'b1;
            owner_r[qi] <= {rc.pid, rc.aid};
            rec_r[cur_r].res   <= 1'b1;
            rec_r[cur_r].start <= qi;
            if (lru_cnt_r < LRC_W'(bale_pkg::NUM_PAGES)) begin
              lru_r[lru_cnt_r[PG_W-1:0]] <= qi;
              lru_cnt_r <= lru_cnt_r + LRC_W'(1);
            end
            state_r <= ST_FIN;
          end
        end
        // LRU removal: find entry and shift the rest down
        ST_LRM: begin
          if (li_r >= lru_cnt_r) begin
            if (lfound_r) lru_cnt_r <= lru_cnt_r - LRC_W'(1);
            state_r <= sub_ret_r;
          end else begin
            if (lf && li_nx < lru_cnt_r) lru_r[li_r[PG_W-1:0]] <= lru_r[li_nx[PG_W-1:0]];
            lfound_r <= lf;
            li_r     <= li_nx;
          end
        end
        // block free with buddy merge
        ST_FR_INIT: begin
          o_r          <= order_r[s_r];
          used_r[s_r]  <= 1'b0;
          owner_r[s_r] <= '0;
          state_r      <= ST_FR_CHK;
        end
        ST_FR_CHK: begin
          if (32'(o_r) >= bale_pkg::POOL_ORDER) begin
            state_r <= sub_ret_r;
          end else begin
            b_r     <= s_r ^ (PG_W'(1) << o_r);
            q_r     <= '0;
            state_r <= ST_FR_WALK;
          end
        end
        ST_FR_WALK: begin
          if (q_r >= PGC_W'(bale_pkg::POOL_PAGES) || q_r > PGC_W'(b_r)) begin
            state_r <= sub_ret_r;
          end else if (q_r == PGC_W'(b_r)) begin
            if (order_r[b_r] == o_r && !used_r[b_r]) begin
              if (b_r < s_r) begin
                s_r          <= b_r;
                order_r[b_r] <= o_r + ORD_W'(1);
                used_r[b_r]  <= 1'b0;
                owner_r[b_r] <= '0;
              end else begin
                order_r[s_r] <= o_r + ORD_W'(1);
                used_r[s_r]  <= 1'b0;
                owner_r[s_r] <= '0;
              end
              o_r     <= o_r + ORD_W'(1);
              state_r <= ST_FR_CHK;
            end else begin
              state_r <= sub_ret_r;
            end
          end else begin
            q_r <= q_step;
          end
        end
        ST_FIN: begin
          if (ok) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
